// ===== rtl/core/bfern_pkg.sv =====
package bfern_pkg;

   localparam int POS_FRAC_BITS_DEF = 16;
   localparam int COEF_W = 18;

   // cumulative map thresholds for a Q0.16 draw
   localparam logic [15:0] THRESH_1 = 16'd656;
   localparam logic [15:0] THRESH_2 = 16'd5243;
   localparam logic [15:0] THRESH_3 = 16'd9831;

   // y offsets as Q32
   localparam logic [63:0] OFF_1P6_Q32  = 64'd6871947674;
   localparam logic [63:0] OFF_0P44_Q32 = 64'd1889785610;

   localparam logic signed [COEF_W-1:0] PLOT_SCALE = 18'sd4915;
   localparam logic [15:0] PLOT_X_BIAS = 16'd32768;
   localparam logic [15:0] PLOT_Y_BIAS = 16'd6554;

   typedef logic [1:0] map_type;
   typedef logic [1:0] chan_type;

   localparam map_type MAP_STEM  = 2'd0;
   localparam map_type MAP_LEFT  = 2'd1;
   localparam map_type MAP_RIGHT = 2'd2;
   localparam map_type MAP_MAIN  = 2'd3;

   localparam chan_type CH_RED   = 2'd0;
   localparam chan_type CH_GREEN = 2'd1;
   localparam chan_type CH_BLUE  = 2'd2;

   function automatic map_type map_select(input logic [15:0] z);
      map_type m;
      if (z < THRESH_1) m = MAP_STEM;
      else if (z < THRESH_2) m = MAP_LEFT;
      else if (z < THRESH_3) m = MAP_RIGHT;
      else m = MAP_MAIN;
      return m;
   endfunction

   // x from x
   function automatic logic signed [COEF_W-1:0] coef_a(input map_type m);
      logic signed [COEF_W-1:0] c;
      unique case (m)
         MAP_STEM:  c = 18'sd0;
         MAP_LEFT:  c = 18'sd13107;
         MAP_RIGHT: c = -18'sd9830;
         default:   c = 18'sd55706;
      endcase
      return c;
   endfunction

   // x from y
   function automatic logic signed [COEF_W-1:0] coef_b(input map_type m);
      logic signed [COEF_W-1:0] c;
      unique case (m)
         MAP_STEM:  c = 18'sd0;
         MAP_LEFT:  c = -18'sd17039;
         MAP_RIGHT: c = 18'sd18350;
         default:   c = 18'sd2621;
      endcase
      return c;
   endfunction

   // y from x
   function automatic logic signed [COEF_W-1:0] coef_c(input map_type m);
      logic signed [COEF_W-1:0] c;
      unique case (m)
         MAP_STEM:  c = 18'sd0;
         MAP_LEFT:  c = 18'sd15073;
         MAP_RIGHT: c = 18'sd17039;
         default:   c = -18'sd2621;
      endcase
      return c;
   endfunction

   // y from y
   function automatic logic signed [COEF_W-1:0] coef_d(input map_type m);
      logic signed [COEF_W-1:0] c;
      unique case (m)
         MAP_STEM:  c = 18'sd10486;
         MAP_LEFT:  c = 18'sd14418;
         MAP_RIGHT: c = 18'sd15729;
         default:   c = 18'sd55706;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] blend_weight(input map_type m);
      logic [15:0] p;
      unique case (m)
         MAP_STEM:  p = 16'd655;
         MAP_LEFT:  p = 16'd4588;
         MAP_RIGHT: p = 16'd4588;
         default:   p = 16'd55706;
      endcase
      return p;
   endfunction

   // target*(65536-p) + rounding half, per map and channel
   function automatic logic [32:0] blend_base(input map_type m, input chan_type ch);
      logic [32:0] k;
      case ({m, ch})
         {MAP_STEM, CH_RED}:    k = 33'd1594548224;
         {MAP_STEM, CH_GREEN}:  k = 33'd1063043072;
         {MAP_STEM, CH_BLUE}:   k = 33'd212647805;
         {MAP_LEFT, CH_RED}:    k = 33'd499318784;
         {MAP_LEFT, CH_GREEN}:  k = 33'd1997176832;
         {MAP_LEFT, CH_BLUE}:   k = 33'd1497890816;
         {MAP_RIGHT, CH_RED}:   k = 33'd998604800;
         {MAP_RIGHT, CH_GREEN}: k = 33'd1997176832;
         {MAP_RIGHT, CH_BLUE}:  k = 33'd998604800;
         {MAP_MAIN, CH_RED}:    k = 33'd32245678;
         {MAP_MAIN, CH_GREEN}:  k = 33'd161087488;
         {MAP_MAIN, CH_BLUE}:   k = 33'd32245678;
         default:               k = 33'd32768;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/barnsley_fern_ifs_step_core.sv =====
// Barnsley fern chaos-game step. Each request transfer carries a Q0.16 random draw and a
// frame-start flag; the draw picks one of the four fern maps, the point moves and the color
// blends toward that map's color, and one response gives the plot point and color. A single
// signed multiplier (position or color by an 18-bit constant) is used nine times per item under
// a step counter, with a product register between uses, so the next request is taken only
// after the last step of the item; req_stall is high while a step is in
// progress. The response sits in its own register, so a new request is taken while the previous
// response waits; the last step holds only if that response has still not been taken.
module barnsley_fern_ifs_step_core #(
   parameter int POS_FRAC_BITS = bfern_pkg::POS_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_random_fraction,
   input  logic        req_start_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_point_x,
   output logic [15:0] rsp_point_y,
   output logic [15:0] rsp_red,
   output logic [15:0] rsp_green,
   output logic [15:0] rsp_blue
);
   import bfern_pkg::*;

   localparam int W  = POS_FRAC_BITS + 8;
   localparam int PW = W + 1 + COEF_W;
   localparam int AW = PW + 1;

   localparam logic [63:0] OFF_HI_Q =
      (OFF_1P6_Q32 + (64'd1 << (31 - POS_FRAC_BITS))) >> (32 - POS_FRAC_BITS);
   localparam logic [63:0] OFF_LO_Q =
      (OFF_0P44_Q32 + (64'd1 << (31 - POS_FRAC_BITS))) >> (32 - POS_FRAC_BITS);

   localparam logic signed [AW-1:0] POS_MAX = AW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [AW-1:0] POS_MIN = -POS_MAX - AW'(1);
   localparam logic signed [AW-1:0] HALF_16 = AW'(32768);
   localparam logic signed [AW-1:0] HALF_PLOT = AW'(64'd1 << (POS_FRAC_BITS - 1));

   localparam logic [3:0] ST_MUL_AX  = 4'd0;
   localparam logic [3:0] ST_MUL_BY  = 4'd1;
   localparam logic [3:0] ST_MUL_CX  = 4'd2;
   localparam logic [3:0] ST_MUL_DY  = 4'd3;
   localparam logic [3:0] ST_PLOT_X  = 4'd4;
   localparam logic [3:0] ST_PLOT_Y  = 4'd5;
   localparam logic [3:0] ST_RED     = 4'd6;
   localparam logic [3:0] ST_GREEN   = 4'd7;
   localparam logic [3:0] ST_BLUE    = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   logic                 busy_ff, busy_in;
   logic [3:0]           step_ff, step_in;
   map_type              map_ff, map_in;
   logic signed [W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [15:0]          color_r_ff, color_r_in, color_g_ff, color_g_in;
   logic [15:0]          color_b_ff, color_b_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [15:0]          plot_x_ff, plot_x_in, plot_y_ff, plot_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [15:0]          rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic signed [W:0]        mul_a;
   logic signed [COEF_W-1:0] mul_b;
   logic signed [AW-1:0]     prod_ext, pair_sum, pair_rnd, y_rnd, plot_v, pos_new;
   logic signed [W-1:0]      off_sel;
   logic [32:0]              color_sum;
   logic [15:0]              color_new, plot_bias, plot_sat;
   logic                     req_take, out_free;

   assign req_take = req_valid && !busy_ff;
   assign out_free = !(rsp_valid_ff && rsp_stall);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         ST_MUL_AX: begin mul_a = {pos_x_ff[W-1], pos_x_ff}; mul_b = coef_a(map_ff); end
         ST_MUL_BY: begin mul_a = {pos_y_ff[W-1], pos_y_ff}; mul_b = coef_b(map_ff); end
         ST_MUL_CX: begin mul_a = {pos_x_ff[W-1], pos_x_ff}; mul_b = coef_c(map_ff); end
         ST_MUL_DY: begin mul_a = {pos_y_ff[W-1], pos_y_ff}; mul_b = coef_d(map_ff); end
         ST_PLOT_X: begin mul_a = {pos_x_ff[W-1], pos_x_ff}; mul_b = PLOT_SCALE; end
         ST_PLOT_Y: begin mul_a = {pos_y_ff[W-1], pos_y_ff}; mul_b = PLOT_SCALE; end
         ST_RED: begin
            mul_a = $signed({{(W-15){1'b0}}, color_r_ff});
            mul_b = $signed({2'b00, blend_weight(map_ff)});
         end
         ST_GREEN: begin
            mul_a = $signed({{(W-15){1'b0}}, color_g_ff});
            mul_b = $signed({2'b00, blend_weight(map_ff)});
         end
         ST_BLUE: begin
            mul_a = $signed({{(W-15){1'b0}}, color_b_ff});
            mul_b = $signed({2'b00, blend_weight(map_ff)});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = PW'(mul_a) * PW'(mul_b);
   assign prod_ext = {prod_ff[PW-1], prod_ff};
   assign pair_sum = acc_ff + prod_ext;
   assign pair_rnd = (pair_sum + HALF_16) >>> 16;

   always_comb begin
      case (map_ff)
         MAP_STEM:  off_sel = '0;
         MAP_RIGHT: off_sel = OFF_LO_Q[W-1:0];
         default:   off_sel = OFF_HI_Q[W-1:0];
      endcase
   end

   assign y_rnd = pair_rnd + {{(AW-W){off_sel[W-1]}}, off_sel};

   // new coordinate with saturation to the state width
   always_comb begin
      pos_new = (step_ff == ST_PLOT_X) ? y_rnd : pair_rnd;
      if (pos_new > POS_MAX) pos_new = POS_MAX;
      else if (pos_new < POS_MIN) pos_new = POS_MIN;
   end

   // plot x product lands during the plot y step
   assign plot_bias = (step_ff == ST_PLOT_Y) ? PLOT_X_BIAS : PLOT_Y_BIAS;
   assign plot_v = ((prod_ext + HALF_PLOT) >>> POS_FRAC_BITS)
                   + $signed({{(AW-16){1'b0}}, plot_bias});

   always_comb begin
      if (plot_v < 0) plot_sat = 16'd0;
      else if (plot_v > $signed(AW'(65535))) plot_sat = 16'hffff;
      else plot_sat = plot_v[15:0];
   end

   // blend: each color sum is formed in the step after its multiply
   always_comb begin
      case (step_ff)
         ST_GREEN: color_sum = prod_ff[32:0] + blend_base(map_ff, CH_RED);
         ST_BLUE:  color_sum = prod_ff[32:0] + blend_base(map_ff, CH_GREEN);
         default:  color_sum = prod_ff[32:0] + blend_base(map_ff, CH_BLUE);
      endcase
   end
   assign color_new = color_sum[31:16];

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      map_in       = map_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      color_r_in   = color_r_ff;
      color_g_in   = color_g_ff;
      color_b_in   = color_b_ff;
      acc_in       = acc_ff;
      plot_x_in    = plot_x_ff;
      plot_y_in    = plot_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;

      if (req_take) begin
         busy_in = 1'b1;
         step_in = ST_MUL_AX;
         map_in  = map_select(req_random_fraction);
         if (req_start_frame) begin
            pos_x_in   = '0;
            pos_y_in   = '0;
            color_r_in = '0;
            color_g_in = '0;
            color_b_in = '0;
         end
      end else if (busy_ff) begin
         if (step_ff != ST_DONE) step_in = step_ff + 4'd1;
         unique case (step_ff)
            ST_MUL_AX: ;
            ST_MUL_BY: acc_in = prod_ext;
            ST_MUL_CX: pos_x_in = pos_new[W-1:0];
            ST_MUL_DY: acc_in = prod_ext;
            ST_PLOT_X: pos_y_in = pos_new[W-1:0];
            ST_PLOT_Y: plot_x_in = plot_sat;
            ST_RED:    plot_y_in = plot_sat;
            ST_GREEN:  color_r_in = color_new;
            ST_BLUE:   color_g_in = color_new;
            ST_DONE: begin
               if (out_free) begin
                  color_b_in   = color_new;
                  busy_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = plot_x_ff;
                  rsp_y_in     = plot_y_ff;
                  rsp_r_in     = color_r_ff;
                  rsp_g_in     = color_g_ff;
                  rsp_b_in     = color_new;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_MUL_AX;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         color_r_ff   <= '0;
         color_g_ff   <= '0;
         color_b_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         color_r_ff   <= color_r_in;
         color_g_ff   <= color_g_in;
         color_b_ff   <= color_b_in;
      end
   end

   always_ff @(posedge clock) begin
      map_ff    <= map_in;
      acc_ff    <= acc_in;
      plot_x_ff <= plot_x_in;
      plot_y_ff <= plot_y_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_r_ff  <= rsp_r_in;
      rsp_g_ff  <= rsp_g_in;
      rsp_b_ff  <= rsp_b_in;
      // keep the last product while the final step waits on the response register
      if (step_ff != ST_DONE) prod_ff <= prod_in;
   end

   assign req_stall   = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_red     = rsp_r_ff;
   assign rsp_green   = rsp_g_ff;
   assign rsp_blue    = rsp_b_ff;

endmodule

// ===== verif/bfern_step_checker.sv =====
module bfern_step_checker #(
   parameter int FRAC = bfern_pkg::POS_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_random_fraction,
   input  logic        req_start_frame,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_point_x,
   input  logic [15:0] rsp_point_y,
   input  logic [15:0] rsp_red,
   input  logic [15:0] rsp_green,
   input  logic [15:0] rsp_blue,
   output int          mismatches,
   output int          in_flight
);
   timeunit 1ns;
   timeprecision 1ps;
   import bfern_pkg::*;

   localparam int PW = FRAC + 8;

   typedef struct {
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } plot_sample;

   plot_sample plot_queue[$];

   logic signed [PW-1:0] fern_x = '0;
   logic signed [PW-1:0] fern_y = '0;
   logic [15:0] hue_r = '0;
   logic [15:0] hue_g = '0;
   logic [15:0] hue_b = '0;

   // round to nearest, ties toward +inf
   function automatic longint round_shift(input longint s, input int sh);
      return (s + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_pos(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (PW - 1)) - 1;
      lo = -(longint'(1) <<< (PW - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic logic [15:0] plot_coord(input longint p, input longint bias);
      longint v;
      v = round_shift(p * 4915, FRAC) + bias;
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hffff;
      return v[15:0];
   endfunction

   function automatic logic [15:0] mix(input logic [15:0] c, input longint p, input longint t);
      longint s;
      s = longint'(c) * p + t * (65536 - p) + 32768;
      s = s >>> 16;
      return s[15:0];
   endfunction

   task automatic predict_step(input logic [15:0] z, input logic new_frame);
      map_type m;
      longint ca, cb, cc, cd, off_q32, wt, tr, tg, tb;
      longint px, py, off, nx, ny;
      plot_sample s;
      if (new_frame) begin
         fern_x = '0;
         fern_y = '0;
         hue_r = '0;
         hue_g = '0;
         hue_b = '0;
      end
      if (z < THRESH_1) m = MAP_STEM;
      else if (z < THRESH_2) m = MAP_LEFT;
      else if (z < THRESH_3) m = MAP_RIGHT;
      else m = MAP_MAIN;
      case (m)
         MAP_STEM: begin
            ca = 0; cb = 0; cc = 0; cd = 10486; off_q32 = 0;
            wt = 655; tr = 24576; tg = 16384; tb = 3277;
         end
         MAP_LEFT: begin
            ca = 13107; cb = -17039; cc = 15073; cd = 14418; off_q32 = 64'sd6871947674;
            wt = 4588; tr = 8192; tg = 32768; tb = 24576;
         end
         MAP_RIGHT: begin
            ca = -9830; cb = 18350; cc = 17039; cd = 15729; off_q32 = 64'sd1889785610;
            wt = 4588; tr = 16384; tg = 32768; tb = 16384;
         end
         default: begin
            ca = 55706; cb = 2621; cc = -2621; cd = 55706; off_q32 = 64'sd6871947674;
            wt = 55706; tr = 3277; tg = 16384; tb = 3277;
         end
      endcase
      px = longint'(fern_x);
      py = longint'(fern_y);
      // y offset rounded from Q32 into the position format
      off = (off_q32 + (longint'(1) <<< (31 - FRAC))) >>> (32 - FRAC);
      nx = clamp_pos(round_shift(ca * px + cb * py, 16));
      ny = clamp_pos(round_shift(cc * px + cd * py, 16) + off);
      fern_x = nx[PW-1:0];
      fern_y = ny[PW-1:0];
      hue_r = mix(hue_r, wt, tr);
      hue_g = mix(hue_g, wt, tg);
      hue_b = mix(hue_b, wt, tb);
      s.px = plot_coord(nx, 32768);
      s.py = plot_coord(ny, 6554);
      s.r = hue_r;
      s.g = hue_g;
      s.b = hue_b;
      plot_queue.push_back(s);
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      plot_sample want;
      if (reset) begin
         fern_x = '0;
         fern_y = '0;
         hue_r = '0;
         hue_g = '0;
         hue_b = '0;
         plot_queue.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_step(req_random_fraction, req_start_frame);
         if (rsp_valid && !rsp_stall) begin
            if (plot_queue.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = plot_queue.pop_front();
               check_field("point_x", want.px, rsp_point_x);
               check_field("point_y", want.py, rsp_point_y);
               check_field("red", want.r, rsp_red);
               check_field("green", want.g, rsp_green);
               check_field("blue", want.b, rsp_blue);
            end
         end
      end
      in_flight = plot_queue.size();
   end

endmodule

// ===== verif/barnsley_fern_ifs_step_core_tb.sv =====
module barnsley_fern_ifs_step_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfern_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_random_fraction = '0;
   logic        req_start_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_point_x;
   logic [15:0] rsp_point_y;
   logic [15:0] rsp_red;
   logic [15:0] rsp_green;
   logic [15:0] rsp_blue;
   int          mismatches;
   int          in_flight;

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int quiet_cycles = 0;

   barnsley_fern_ifs_step_core dut (.*);

   bfern_step_checker checker_i (.*);

   always #4 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_gap_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_draw(input logic [15:0] z, input logic new_frame);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_random_fraction <= z;
      req_start_frame <= new_frame;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (in_flight != 0) @(negedge clock);
   endtask

   // mostly uniform draws, some clustered on the map thresholds
   function automatic logic [15:0] pick_draw();
      logic [15:0] near;
      case ($urandom_range(2))
         0: near = THRESH_1;
         1: near = THRESH_2;
         default: near = THRESH_3;
      endcase
      if ($urandom_range(99) < 15)
         return near + 16'($urandom_range(4)) - 16'd2;
      return 16'($urandom);
   endfunction

   task automatic random_run(input int count);
      repeat (count) send_draw(pick_draw(), $urandom_range(99) < 3);
   endtask

   initial begin
      send_gap_pct = 20;
      recv_gap_pct = 46;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_draw(16'd0, 1'b1);
      send_draw(THRESH_1 - 16'd1, 1'b0);
      send_draw(THRESH_1, 1'b0);
      send_draw(THRESH_2 - 16'd1, 1'b0);
      send_draw(THRESH_2, 1'b0);
      send_draw(THRESH_3 - 16'd1, 1'b0);
      send_draw(THRESH_3, 1'b0);
      send_draw(16'hffff, 1'b0);
      send_draw(16'd0, 1'b0);
      send_draw(16'd0, 1'b0);
      send_draw(16'hffff, 1'b1);
      send_draw(16'hfffe, 1'b0);
      send_draw(16'h8000, 1'b0);
      send_draw(16'd1, 1'b0);
      send_draw(16'd3000, 1'b0);
      send_draw(16'd7000, 1'b0);
      send_draw(16'h5555, 1'b0);
      send_draw(16'haaaa, 1'b0);
      send_draw(16'd0, 1'b1);
      send_draw(THRESH_2, 1'b1);
      send_draw(THRESH_3 - 16'd1, 1'b1);
      send_draw(16'hffff, 1'b0);
      drain();

      random_run(316);
      drain();

      send_gap_pct = 46;
      recv_gap_pct = 20;
      random_run(317);
      drain();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      random_run(317);
      drain();

      repeat (30) @(posedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
